@@ rtl/pctd_pkg.sv @@
// shared types, character codes and hex helpers for the percent decoder
`default_nettype none

package pctd_pkg;

  // character codes
  localparam logic [7:0] CharPercent = 8'h25;
  localparam logic [7:0] CharPlus    = 8'h2B;
  localparam logic [7:0] CharSpace   = 8'h20;
  localparam logic [7:0] CharZero    = 8'h30;
  localparam logic [7:0] CharNine    = 8'h39;
  localparam logic [7:0] CharUpperA  = 8'h41;
  localparam logic [7:0] CharUpperF  = 8'h46;
  localparam logic [7:0] CharLowerA  = 8'h61;
  localparam logic [7:0] CharLowerF  = 8'h66;

  // escape tracking phases
  localparam logic [1:0] PhaseIdle = 2'd0;
  localparam logic [1:0] PhasePct  = 2'd1;
  localparam logic [1:0] PhaseHex  = 2'd2;

  // one source character yields up to three decoded characters
  localparam int unsigned MaxBurst  = 3;
  localparam int unsigned BurstIdxW = $clog2(MaxBurst + 1);

  // queue between classifier and serializer
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // decoded characters produced by one source character
  typedef struct packed {
    logic [BurstIdxW-1:0]     cnt;
    logic [MaxBurst-1:0][7:0] chars;
    logic                     last;
  } burst_t;

  // burst plus its valid flag, used on both sides of the queue
  typedef struct packed {
    logic   valid;
    burst_t burst;
  } burst_req_t;

  function automatic logic is_hex(logic [7:0] c);
    return ((c >= CharZero) && (c <= CharNine)) ||
           ((c >= CharUpperA) && (c <= CharUpperF)) ||
           ((c >= CharLowerA) && (c <= CharLowerF));
  endfunction

  // nibble of a character already known to be a hex digit
  function automatic logic [3:0] hex_val(logic [7:0] c);
    return (c <= CharNine) ? c[3:0] : (c[3:0] + 4'd9);
  endfunction

  // add one character to the end of a burst
  function automatic burst_t append(burst_t b, logic [7:0] ch);
    burst_t r;
    r = b;
    if (r.cnt != BurstIdxW'(MaxBurst)) begin
      r.chars[r.cnt] = ch;
      r.cnt          = r.cnt + BurstIdxW'(1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/percent_decoder.sv @@
// top level of the streaming URL percent decoder
//
// Input channel (in_valid_i / in_ready_o) takes one encoded character per item,
// with in_last_i set on the character that ends the string. Output channel
// (out_valid_o / out_ready_i) gives one decoded character per item, out_last_o
// marking the final character of the string. "%hh" becomes one byte, "+" a
// space, a broken or cut-off escape is passed through literally.
// With the queue and output register empty, the first result of an item is
// registered in the queue, then in the output register, before it is offered.
// Throughput: one input item per cycle while each item yields at most one
// result and the receiver takes every result; an item that yields two or
// three results occupies the output register once per result, since the
// serializer sends one character a cycle while the receiver is ready. A
// two-entry burst queue sits between the escape classifier and the
// serializer, so the input keeps flowing while a result waits.
// Reset clears the escape state, the queue and the output valid; the block
// takes items right out of reset. When the receiver stalls, the output holds
// its character, the queue fills, then in_ready_o drops.
`default_nettype none

module percent_decoder (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_char_i,
  input  wire logic       in_last_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_char_o,
  output logic            out_last_o
);

  pctd_pkg::burst_req_t push;
  pctd_pkg::burst_req_t head;
  logic                 full;
  logic                 pop;

  // escape classification
  pctd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_char_i  (in_char_i),
    .in_last_i  (in_last_i),
    .full_i     (full),
    .push_o     (push)
  );

  // burst queue
  pctd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (full),
    .pop_i  (pop),
    .head_o (head)
  );

  // character serializer
  pctd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_char_o  (out_char_o),
    .out_last_o  (out_last_o)
  );

endmodule

`default_nettype wire

@@ rtl/pctd_front.sv @@
// front end: accepts source characters, tracks escapes and forms output bursts
`default_nettype none

module pctd_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [7:0]          in_char_i,
  input  wire logic                in_last_i,
  input  wire logic                full_i,
  output pctd_pkg::burst_req_t     push_o
);

  logic [1:0]       phase_q, phase_d;
  logic [7:0]       held_q, held_d;
  logic             accept;
  logic             c_hex;
  logic             fresh_pct;
  logic [7:0]       fresh_ch;
  pctd_pkg::burst_t b;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  // classification of the incoming character
  assign c_hex     = pctd_pkg::is_hex(in_char_i);
  assign fresh_pct = (in_char_i == pctd_pkg::CharPercent);
  assign fresh_ch  = (in_char_i == pctd_pkg::CharPlus) ? pctd_pkg::CharSpace : in_char_i;

  // escape decoding and end-of-string flush
  always_comb begin
    b       = '0;
    phase_d = phase_q;
    held_d  = held_q;
    unique case (phase_q)
      pctd_pkg::PhasePct: begin
        if (c_hex) begin
          held_d  = in_char_i;
          phase_d = pctd_pkg::PhaseHex;
        end else begin
          b       = pctd_pkg::append(b, pctd_pkg::CharPercent);
          phase_d = fresh_pct ? pctd_pkg::PhasePct : pctd_pkg::PhaseIdle;
          if (!fresh_pct) b = pctd_pkg::append(b, fresh_ch);
        end
      end
      pctd_pkg::PhaseHex: begin
        if (c_hex) begin
          b = pctd_pkg::append(b, {pctd_pkg::hex_val(held_q),
                                   pctd_pkg::hex_val(in_char_i)});
          phase_d = pctd_pkg::PhaseIdle;
        end else begin
          b       = pctd_pkg::append(b, pctd_pkg::CharPercent);
          b       = pctd_pkg::append(b, held_q);
          phase_d = fresh_pct ? pctd_pkg::PhasePct : pctd_pkg::PhaseIdle;
          if (!fresh_pct) b = pctd_pkg::append(b, fresh_ch);
        end
      end
      default: begin
        phase_d = fresh_pct ? pctd_pkg::PhasePct : pctd_pkg::PhaseIdle;
        if (!fresh_pct) b = pctd_pkg::append(b, fresh_ch);
      end
    endcase
    if (in_last_i) begin
      if (phase_d == pctd_pkg::PhasePct) begin
        b = pctd_pkg::append(b, pctd_pkg::CharPercent);
      end else if (phase_d == pctd_pkg::PhaseHex) begin
        b = pctd_pkg::append(b, pctd_pkg::CharPercent);
        b = pctd_pkg::append(b, held_d);
      end
      phase_d = pctd_pkg::PhaseIdle;
      held_d  = '0;
    end
    b.last = in_last_i;
  end

  // bursts with at least one character go to the queue
  assign push_o.valid = accept && (b.cnt != '0);
  assign push_o.burst = b;

  // escape state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= pctd_pkg::PhaseIdle;
      held_q  <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/pctd_queue.sv @@
// short queue of decoded bursts between front end and serializer
`default_nettype none

module pctd_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire pctd_pkg::burst_req_t push_i,
  output logic                     full_o,
  input  wire logic                pop_i,
  output pctd_pkg::burst_req_t     head_o
);

  pctd_pkg::burst_t                   mem_q [pctd_pkg::QueueDepth];
  logic [pctd_pkg::QueuePtrW-1:0]     wr_q, rd_q;
  logic [pctd_pkg::QueueCntW-1:0]     cnt_q;
  logic                               do_push, do_pop;

  assign full_o       = (cnt_q == pctd_pkg::QueueCntW'(pctd_pkg::QueueDepth));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.burst = mem_q[rd_q];

  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && head_o.valid;

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_i.burst;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == pctd_pkg::QueuePtrW'(pctd_pkg::QueueDepth - 1)) ?
                '0 : wr_q + pctd_pkg::QueuePtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == pctd_pkg::QueuePtrW'(pctd_pkg::QueueDepth - 1)) ?
                '0 : rd_q + pctd_pkg::QueuePtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + pctd_pkg::QueueCntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - pctd_pkg::QueueCntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/pctd_back.sv @@
// back end: sends the characters of each burst one by one through an output register
`default_nettype none

module pctd_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire pctd_pkg::burst_req_t head_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [7:0]                out_char_o,
  output logic                      out_last_o
);

  logic [pctd_pkg::BurstIdxW-1:0] idx_q, idx_d;
  logic                           valid_q;
  logic [7:0]                     char_q;
  logic                           last_q;
  logic                           load;
  logic                           final_char;

  assign load       = head_i.valid && (!valid_q || out_ready_i);
  assign final_char = (idx_q == head_i.burst.cnt - pctd_pkg::BurstIdxW'(1));
  assign pop_o      = load && final_char;

  // position inside the head burst
  always_comb begin
    idx_d = idx_q;
    if (load) idx_d = final_char ? '0 : idx_q + pctd_pkg::BurstIdxW'(1);
  end

  // output valid and burst position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      idx_q <= idx_d;
      if (load) begin
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= head_i.burst.chars[idx_q];
      last_q <= head_i.burst.last && final_char;
    end
  end

  assign out_valid_o = valid_q;
  assign out_char_o  = char_q;
  assign out_last_o  = last_q;

endmodule

`default_nettype wire

@@ rtl/pctd_checker.sv @@
// port-level checks for the percent decoder, bound to the top level
`default_nettype none

module pctd_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_o,
  input wire logic [7:0] in_char_i,
  input wire logic       in_last_i,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [7:0] out_char_o,
  input wire logic       out_last_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_char_o) && $stable(out_last_o))
    else $error("stalled output item changed");

  // with nothing in the output register the queue cannot be full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled while output is empty");

  // a valid output item carries known bits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !$isunknown({out_char_o, out_last_o}))
    else $error("unknown bits on a valid output item");

  // a final 'z' on an idle output shows up via the queue and output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && in_valid_i && in_ready_o && in_last_i && in_char_i == 8'h7A
      && $past(!out_valid_o) && $past(!in_valid_i)
    |-> ##2 (out_valid_o && ((out_char_o == 8'h7A) || !out_last_o)))
    else $error("final character lost");

endmodule

bind percent_decoder pctd_checker u_pctd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_char_i   (in_char_i),
  .in_last_i   (in_last_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_char_o  (out_char_o),
  .out_last_o  (out_last_o)
);

`default_nettype wire
